### hw/rtl/wale_gradient_magnitude_defines.svh
// Assertion macros used by the checker file.
`ifndef WALE_GRADIENT_MAGNITUDE_DEFINES_SVH
`define WALE_GRADIENT_MAGNITUDE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define WGM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define WGM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/wgm_pkg.sv
`default_nettype none

package wgm_pkg;

	localparam int FIELD_W = 16;
	localparam int NUM_G   = 9;
	localparam int AXES_W  = 3;
	localparam int OUT_W   = 63;
	localparam int SQ_W    = 32;

	localparam logic [AXES_W-1:0] AXES_RESET = 3'b111;
	localparam logic [OUT_W-1:0]  OUT_MAX    = {OUT_W{1'b1}};

	// Axes each component needs, row-major g11 g12 g13 g21 ... g33 (bit0 x, bit1 y, bit2 z)
	localparam logic [AXES_W-1:0] G_NEED [NUM_G] = '{
		3'b001, 3'b011, 3'b101,
		3'b011, 3'b010, 3'b110,
		3'b101, 3'b110, 3'b100
	};

endpackage

`default_nettype wire

### hw/rtl/wgm_hmat.sv
`default_nettype none

// Stages 1..3: mask gradients, form all products, sum into H = G*G.
module wgm_hmat #(
	parameter int GRAD_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [wgm_pkg::AXES_W-1:0]         axes,
	input  logic [wgm_pkg::FIELD_W-1:0]        grad [wgm_pkg::NUM_G],
	output logic                              out_valid,
	output logic signed [2*GRAD_WIDTH+1:0]    h [3][3]
);

	localparam int PW = 2 * GRAD_WIDTH;
	localparam int HW = 2 * GRAD_WIDTH + 2;

	logic [3:1] v_s;
	logic signed [GRAD_WIDTH-1:0] g_s1 [wgm_pkg::NUM_G];
	logic signed [PW-1:0]         p_s2 [3][3][3];
	logic signed [HW-1:0]         h_s3 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[2:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// take the low bits of each field, drop components on disabled axes
			for (int c = 0; c < wgm_pkg::NUM_G; c++) begin
				if ((axes & wgm_pkg::G_NEED[c]) == wgm_pkg::G_NEED[c]) begin
					g_s1[c] <= signed'(GRAD_WIDTH'(grad[c]));
				end else begin
					g_s1[c] <= '0;
				end
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						p_s2[i][j][k] <= g_s1[3*i+k] * g_s1[3*k+j];
					end
					h_s3[i][j] <= HW'(p_s2[i][j][0]) + HW'(p_s2[i][j][1])
						+ HW'(p_s2[i][j][2]);
				end
			end
		end
	end

	assign out_valid = v_s[3];
	assign h         = h_s3;

endmodule

`default_nettype wire

### hw/rtl/wgm_div3.sv
`default_nettype none

// Stages 4..10: trace, pair sums, and trace/3 truncated toward zero.
// |trace| mod 3 comes from a base-4 digit sum; the exact quotient of the
// remaining multiple of 3 is a multiply by the inverse of 3 mod 2^MW,
// built as a shift-add doubling chain.
module wgm_div3 #(
	parameter int GRAD_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [2*GRAD_WIDTH+1:0]    h [3][3],
	output logic                              out_valid,
	output logic [2*GRAD_WIDTH+2:0]           q,
	output logic                              neg,
	output logic signed [2*GRAD_WIDTH+1:0]    hd [3],
	output logic signed [2*GRAD_WIDTH+2:0]    ps [3]
);

	localparam int HW     = 2 * GRAD_WIDTH + 2;
	localparam int PW     = 2 * GRAD_WIDTH + 3;
	localparam int TW     = 2 * GRAD_WIDTH + 4;
	localparam int MW     = TW - 1;
	localparam int ND     = (MW + 1) / 2;
	localparam int DSUM_W = 8;

	function automatic logic [1:0] mod3_small(input logic [DSUM_W-1:0] v);
		logic [3:0] a;
		logic [2:0] b;
		a = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		b = 3'(a[1:0]) + 3'(a[3:2]);
		if (b >= 3'd3) b = b - 3'd3;
		if (b >= 3'd3) b = b - 3'd3;
		return b[1:0];
	endfunction

	logic [10:4] v_s;
	logic signed [TW-1:0] tr_s4;
	logic signed [HW-1:0] hd_s [4:10][3];
	logic signed [PW-1:0] ps_s [4:10][3];
	logic                 neg_s [5:10];
	logic [MW-1:0]        tmag_s5, tmag_s6;
	logic [DSUM_W-1:0]    dsum_s6;
	logic [MW-1:0]        y_s7, y_s8, y_s9;
	logic [MW-1:0]        a_s8, a_s9, q_s10;

	logic [DSUM_W-1:0] dsum_c;
	logic [2*ND-1:0]   tpad;
	logic [MW-1:0]     b_c, c_c, e_c;
	logic signed [TW-1:0] tneg_c;

	always_comb begin
		tpad   = (2*ND)'(tmag_s5);
		dsum_c = '0;
		for (int k = 0; k < ND; k++) begin
			dsum_c = dsum_c + DSUM_W'(tpad[2*k +: 2]);
		end
		tneg_c = -tr_s4;
		b_c    = y_s7 + (y_s7 << 2);
		c_c    = a_s8 + (a_s8 << 8);
		e_c    = a_s9 + (a_s9 << 32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[9:4], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tr_s4 <= TW'(h[0][0]) + TW'(h[1][1]) + TW'(h[2][2]);
			for (int i = 0; i < 3; i++) begin
				hd_s[4][i] <= h[i][i];
			end
			ps_s[4][0] <= PW'(h[0][1]) + PW'(h[1][0]);
			ps_s[4][1] <= PW'(h[0][2]) + PW'(h[2][0]);
			ps_s[4][2] <= PW'(h[1][2]) + PW'(h[2][1]);
			for (int s = 5; s <= 10; s++) begin
				hd_s[s] <= hd_s[s-1];
				ps_s[s] <= ps_s[s-1];
			end

			neg_s[5] <= tr_s4[TW-1];
			for (int s = 6; s <= 10; s++) begin
				neg_s[s] <= neg_s[s-1];
			end
			tmag_s5 <= tr_s4[TW-1] ? tneg_c[MW-1:0] : tr_s4[MW-1:0];

			tmag_s6 <= tmag_s5;
			dsum_s6 <= dsum_c;

			// drop the remainder so the quotient is exact
			y_s7 <= tmag_s6 - MW'(mod3_small(dsum_s6));
			y_s8 <= y_s7;
			y_s9 <= y_s8;

			a_s8  <= b_c + (b_c << 4);
			a_s9  <= c_c + (c_c << 16);
			q_s10 <= y_s9 + (e_c << 1);
		end
	end

	assign out_valid = v_s[10];
	assign q         = q_s10;
	assign neg       = neg_s[10];
	assign hd        = hd_s[10];
	assign ps        = ps_s[10];

endmodule

`default_nettype wire

### hw/rtl/wgm_norm.sv
`default_nettype none

// Stages 11..16: deviations, saturating squares, saturating sum.
module wgm_norm #(
	parameter int GRAD_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [2*GRAD_WIDTH+2:0]           q,
	input  logic                              neg,
	input  logic signed [2*GRAD_WIDTH+1:0]    hd [3],
	input  logic signed [2*GRAD_WIDTH+2:0]    ps [3],
	output logic                              out_valid,
	output logic [wgm_pkg::OUT_W-1:0]          result
);

	localparam int PW = 2 * GRAD_WIDTH + 3;
	localparam int DW = 2 * GRAD_WIDTH + 5;
	localparam int SQ = wgm_pkg::SQ_W;
	localparam int OW = wgm_pkg::OUT_W;

	logic [16:11] v_s;
	logic signed [DW-1:0] d_s11 [3];
	logic signed [PW-1:0] ps_s11 [3];
	logic [SQ-1:0]        m_s12 [6];
	logic                 sat_s12 [6];
	logic [2*SQ-1:0]      p_s13 [6];
	logic                 sat_s13 [6];
	logic [OW:0]          pr_s14 [3];
	logic [OW+1:0]        sa_s15;
	logic [OW:0]          sb_s15;
	logic [OW-1:0]        res_s16;

	logic signed [63:0] x_c [6];
	logic [63:0]        mag_c [6];
	logic [OW-1:0]      term_c [6];
	logic [OW+2:0]      tot_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			x_c[k]   = 64'(d_s11[k]);
			x_c[k+3] = 64'(ps_s11[k]);
		end
		for (int k = 0; k < 6; k++) begin
			mag_c[k] = x_c[k][63] ? (~x_c[k] + 64'd1) : x_c[k];
		end
		// diagonal terms cap at full scale, pair terms halve
		for (int k = 0; k < 3; k++) begin
			if (sat_s13[k] || p_s13[k][2*SQ-1]) begin
				term_c[k] = wgm_pkg::OUT_MAX;
			end else begin
				term_c[k] = p_s13[k][OW-1:0];
			end
			if (sat_s13[k+3]) begin
				term_c[k+3] = wgm_pkg::OUT_MAX;
			end else begin
				term_c[k+3] = p_s13[k+3][2*SQ-1:1];
			end
		end
		tot_c = (OW+3)'(sa_s15) + (OW+3)'(sb_s15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[15:11], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (neg) begin
					d_s11[k] <= DW'(hd[k]) + DW'(q);
				end else begin
					d_s11[k] <= DW'(hd[k]) - DW'(q);
				end
			end
			ps_s11 <= ps;

			for (int k = 0; k < 6; k++) begin
				m_s12[k]   <= mag_c[k][SQ-1:0];
				sat_s12[k] <= |mag_c[k][63:SQ];
				p_s13[k]   <= m_s12[k] * m_s12[k];
				sat_s13[k] <= sat_s12[k];
			end

			for (int k = 0; k < 3; k++) begin
				pr_s14[k] <= (OW+1)'(term_c[k]) + (OW+1)'(term_c[k+3]);
			end

			sa_s15 <= (OW+2)'(pr_s14[0]) + (OW+2)'(pr_s14[1]);
			sb_s15 <= pr_s14[2];

			if (tot_c > (OW+3)'(wgm_pkg::OUT_MAX)) begin
				res_s16 <= wgm_pkg::OUT_MAX;
			end else begin
				res_s16 <= tot_c[OW-1:0];
			end
		end
	end

	assign out_valid = v_s[16];
	assign result    = res_s16;

endmodule

`default_nettype wire

### hw/rtl/wale_gradient_magnitude.sv
// WALE gradient measure, one grid cell per request. Takes the nine velocity
// gradients g_ij = du_i/dx_j (signed Q8.8, read as GRAD_WIDTH-bit two's
// complement from the low bits of each field), zeroes those on axes that
// active_axes disables, squares the matrix (H = G*G), subtracts trace/3
// (truncated toward zero) from the diagonal, and returns the sum of squared
// diagonal deviations plus half the squared symmetric pair sums as unsigned
// Q31.32, saturated at 2^63-1. Rate: one request per cycle when the output
// is not stalled. The pipeline moves as one; while out_valid is high and
// out_ready low every stage holds and in_ready drops, so the output register
// is the only point where a result waits. Write active_axes (reset 3'b111)
// only while no request is in flight; the value is sampled as a request
// enters.
`default_nettype none

module wale_gradient_magnitude #(
	parameter int GRAD_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wgm_pkg::AXES_W-1:0]       active_axes,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [wgm_pkg::FIELD_W-1:0] du_dx,
	input  logic signed [wgm_pkg::FIELD_W-1:0] du_dy,
	input  logic signed [wgm_pkg::FIELD_W-1:0] du_dz,
	input  logic signed [wgm_pkg::FIELD_W-1:0] dv_dx,
	input  logic signed [wgm_pkg::FIELD_W-1:0] dv_dy,
	input  logic signed [wgm_pkg::FIELD_W-1:0] dv_dz,
	input  logic signed [wgm_pkg::FIELD_W-1:0] dw_dx,
	input  logic signed [wgm_pkg::FIELD_W-1:0] dw_dy,
	input  logic signed [wgm_pkg::FIELD_W-1:0] dw_dz,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [wgm_pkg::OUT_W-1:0]        wale_magnitude
);

	localparam int HW = 2 * GRAD_WIDTH + 2;
	localparam int PW = 2 * GRAD_WIDTH + 3;
	localparam int MW = 2 * GRAD_WIDTH + 3;

	logic [wgm_pkg::AXES_W-1:0]  axes_q;
	logic [wgm_pkg::FIELD_W-1:0] grad_fld [wgm_pkg::NUM_G];
	logic                        en;

	logic                 h_valid;
	logic signed [HW-1:0] h_mat [3][3];
	logic                 t_valid;
	logic [MW-1:0]        t_quot;
	logic                 t_neg;
	logic signed [HW-1:0] t_hd [3];
	logic signed [PW-1:0] t_ps [3];

	// Config register: always ready, write lands on the handshake edge.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axes_q <= wgm_pkg::AXES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			axes_q <= active_axes;
		end
	end

	// Advance the whole pipeline unless the finished result is being held.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Row-major gradient matrix.
	assign grad_fld[0] = du_dx;
	assign grad_fld[1] = du_dy;
	assign grad_fld[2] = du_dz;
	assign grad_fld[3] = dv_dx;
	assign grad_fld[4] = dv_dy;
	assign grad_fld[5] = dv_dz;
	assign grad_fld[6] = dw_dx;
	assign grad_fld[7] = dw_dy;
	assign grad_fld[8] = dw_dz;

	// Stages 1..3: axis masking and H = G*G.
	wgm_hmat #(
		.GRAD_WIDTH(GRAD_WIDTH)
	) u_hmat (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.axes     (axes_q),
		.grad     (grad_fld),
		.out_valid(h_valid),
		.h        (h_mat)
	);

	// Stages 4..10: trace, pair sums, trace/3.
	wgm_div3 #(
		.GRAD_WIDTH(GRAD_WIDTH)
	) u_div3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (h_valid),
		.h        (h_mat),
		.out_valid(t_valid),
		.q        (t_quot),
		.neg      (t_neg),
		.hd       (t_hd),
		.ps       (t_ps)
	);

	// Stages 11..16: squares and saturating sum; stage 16 is the output register.
	wgm_norm #(
		.GRAD_WIDTH(GRAD_WIDTH)
	) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (t_valid),
		.q        (t_quot),
		.neg      (t_neg),
		.hd       (t_hd),
		.ps       (t_ps),
		.out_valid(out_valid),
		.result   (wale_magnitude)
	);

endmodule

`default_nettype wire

### hw/rtl/wgm_checker.sv
`default_nettype none

`include "wale_gradient_magnitude_defines.svh"

module wgm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic signed [wgm_pkg::FIELD_W-1:0] du_dx,
	input logic signed [wgm_pkg::FIELD_W-1:0] du_dy,
	input logic signed [wgm_pkg::FIELD_W-1:0] du_dz,
	input logic signed [wgm_pkg::FIELD_W-1:0] dv_dx,
	input logic signed [wgm_pkg::FIELD_W-1:0] dv_dy,
	input logic signed [wgm_pkg::FIELD_W-1:0] dv_dz,
	input logic signed [wgm_pkg::FIELD_W-1:0] dw_dx,
	input logic signed [wgm_pkg::FIELD_W-1:0] dw_dy,
	input logic signed [wgm_pkg::FIELD_W-1:0] dw_dz,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [wgm_pkg::OUT_W-1:0]        wale_magnitude
);

	// Hold a stalled result and its value.
	`WGM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(wale_magnitude), "stalled result changed or dropped")

	// Hold a waiting request and its gradients.
	`WGM_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable({du_dx, du_dy, du_dz, dv_dx, dv_dy, dv_dz, dw_dx, dw_dy, dw_dz}), "waiting request changed or dropped")

	// Take a new request exactly when the output register can move.
	`WGM_ASSERT_NOW(a_in_ready, 1'b1, in_ready == (!out_valid || out_ready), "in_ready does not follow output stall")

	// Never refuse a config write.
	`WGM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind wale_gradient_magnitude wgm_checker u_wgm_checker (.*);

`default_nettype wire
